### sv/ordered_list_keyed_insert_delete_defines.svh
// Assertion macros for the ordered list block.
// Used by ordered_list_keyed_insert_delete.sv; depends on nothing else.
`ifndef ORDERED_LIST_KEYED_INSERT_DELETE_DEFINES_SVH
`define ORDERED_LIST_KEYED_INSERT_DELETE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OLKID_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OLKID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/olkid_pkg.sv
// Shared types and codes for the ordered list block.
// Used by ordered_list_keyed_insert_delete.sv; depends on nothing.
`default_nettype none

package olkid_pkg;

	localparam int DATA_W = 32;
	localparam int FUNC_W = 3;
	localparam int STAT_W = 2;
	// func, new_value, search_key packed and padded to whole bytes.
	localparam int IN_W   = ((FUNC_W + 2 * DATA_W + 7) / 8) * 8;

	localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_INS_AFTER = 3'd2;
	localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd3;
	localparam logic [FUNC_W-1:0] FN_DEL_BACK  = 3'd4;
	localparam logic [FUNC_W-1:0] FN_DEL_KEY   = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOKEY = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_PEEK,
		S_PEEK_WAIT,
		S_PREP,
		S_SHIFT,
		S_PUT,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

### sv/ordered_list_keyed_insert_delete.sv
// Ordered list of signed 32-bit values with keyed insert and delete.
// Depends on olkid_pkg and ordered_list_keyed_insert_delete_defines.svh.
`default_nettype none
`include "ordered_list_keyed_insert_delete_defines.svh"

// The list sits front to back in a single-port-write, single-port-read memory of
// CAPACITY words, with one equality comparator and an address counter under a small
// sequencer. One command is worked at a time and s_tready is low until it is done.
// Errors and unused codes go straight to the result. A key search reads one entry per
// cycle from the front and stops at the matching entry or after the last one. The
// entries behind the insert or removal point are then moved one by one. Search and
// move cover opposite parts of the list, so removing the front of a full list moves
// every other entry. The memory's one write port and one read port set the pace.
// The result register lets a new command be taken while the last result waits.
module ordered_list_keyed_insert_delete #(
	parameter int CAPACITY = 16,
	localparam int CW = $clog2(CAPACITY + 1),
	localparam int OUT_W = ((olkid_pkg::STAT_W + olkid_pkg::DATA_W + CW + 7) / 8) * 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// Fields from bit 0 up: func[3], new_value[32], search_key[32].
	input  wire logic [olkid_pkg::IN_W-1:0] s_tdata,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// Fields from bit 0 up: status[2], removed_value[32], entry_count[CW].
	output logic [OUT_W-1:0]                m_tdata
);

	localparam int IW = $clog2(CAPACITY);
	localparam int DW = olkid_pkg::DATA_W;

	logic [olkid_pkg::FUNC_W-1:0] in_func;
	logic [DW-1:0]                in_value;
	logic [DW-1:0]                in_key;

	assign in_func  = s_tdata[2:0];
	assign in_value = s_tdata[34:3];
	assign in_key   = s_tdata[66:35];

	olkid_pkg::state_t state_q, state_d;

	logic [olkid_pkg::FUNC_W-1:0] func_q, func_d;
	logic [DW-1:0]                value_q, value_d;
	logic [DW-1:0]                key_q, key_d;
	logic [DW-1:0]                removed_q, removed_d;
	logic [CW-1:0]                pos_q, pos_d;
	logic [CW-1:0]                cnt_q, cnt_d;
	logic [CW-1:0]                ridx_q, ridx_d;
	logic [CW-1:0]                left_q, left_d;
	logic [olkid_pkg::STAT_W-1:0] res_status_q, res_status_d;
	logic [DW-1:0]                res_removed_q, res_removed_d;

	logic          pend_s1, pend_d;
	logic [IW-1:0] dst_s1, dst_d;
	logic          srch_s1, srch_d;
	logic [IW-1:0] sidx_s1, sidx_d;

	logic                         m_valid_q;
	logic [olkid_pkg::STAT_W-1:0] o_status_q;
	logic [DW-1:0]                o_removed_q;
	logic [CW-1:0]                o_count_q;
	logic                         out_load;

	logic          rd_en, wr_en;
	logic [IW-1:0] rd_addr, wr_addr;
	logic [DW-1:0] wr_data;
	logic [DW-1:0] rd_data_s1;
	logic [DW-1:0] mem [CAPACITY];

	logic s_acc;
	logic is_ins;
	logic key_hit;

	assign s_tready = (state_q == olkid_pkg::S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign is_ins   = (func_q == olkid_pkg::FN_INS_FRONT) || (func_q == olkid_pkg::FN_INS_BACK)
		|| (func_q == olkid_pkg::FN_INS_AFTER);
	// The one comparator, shared by every step of a key search.
	assign key_hit  = (rd_data_s1 == key_q);

	always_comb begin
		state_d       = state_q;
		func_d        = func_q;
		value_d       = value_q;
		key_d         = key_q;
		removed_d     = removed_q;
		pos_d         = pos_q;
		cnt_d         = cnt_q;
		ridx_d        = ridx_q;
		left_d        = left_q;
		res_status_d  = res_status_q;
		res_removed_d = res_removed_q;
		pend_d        = 1'b0;
		dst_d         = dst_s1;
		srch_d        = 1'b0;
		sidx_d        = sidx_s1;
		rd_en         = 1'b0;
		rd_addr       = ridx_q[IW-1:0];
		wr_en         = 1'b0;
		wr_addr       = dst_s1;
		wr_data       = rd_data_s1;
		out_load      = 1'b0;

		unique case (state_q)
			olkid_pkg::S_IDLE: begin
				if (s_acc) begin
					func_d        = in_func;
					value_d       = in_value;
					key_d         = in_key;
					ridx_d        = '0;
					res_status_d  = olkid_pkg::ST_OK;
					res_removed_d = '0;
					state_d       = olkid_pkg::S_DONE;
					case (in_func) inside
						olkid_pkg::FN_INS_FRONT, olkid_pkg::FN_INS_BACK,
						olkid_pkg::FN_INS_AFTER: begin
							if (cnt_q == CW'(CAPACITY)) begin
								res_status_d = olkid_pkg::ST_FULL;
							end else if (in_func == olkid_pkg::FN_INS_FRONT) begin
								pos_d   = '0;
								state_d = olkid_pkg::S_PREP;
							end else if (in_func == olkid_pkg::FN_INS_BACK) begin
								pos_d   = cnt_q;
								state_d = olkid_pkg::S_PREP;
							end else if (cnt_q == '0) begin
								res_status_d = olkid_pkg::ST_EMPTY;
							end else begin
								state_d = olkid_pkg::S_SEARCH;
							end
						end
						olkid_pkg::FN_DEL_FRONT, olkid_pkg::FN_DEL_BACK,
						olkid_pkg::FN_DEL_KEY: begin
							if (cnt_q == '0) begin
								res_status_d = olkid_pkg::ST_EMPTY;
							end else if (in_func == olkid_pkg::FN_DEL_FRONT) begin
								pos_d   = '0;
								state_d = olkid_pkg::S_PEEK;
							end else if (in_func == olkid_pkg::FN_DEL_BACK) begin
								pos_d   = cnt_q - CW'(1);
								state_d = olkid_pkg::S_PEEK;
							end else begin
								state_d = olkid_pkg::S_SEARCH;
							end
						end
						default: begin
							res_status_d = olkid_pkg::ST_OK;
						end
					endcase
				end
			end
			olkid_pkg::S_SEARCH: begin
				// Reads run one entry ahead of the compare.
				if (srch_s1 && key_hit) begin
					removed_d = rd_data_s1;
					pos_d     = is_ins ? CW'(sidx_s1) + CW'(1) : CW'(sidx_s1);
					state_d   = olkid_pkg::S_PREP;
				end else if (srch_s1 && (CW'(sidx_s1) == cnt_q - CW'(1))) begin
					res_status_d  = olkid_pkg::ST_NOKEY;
					res_removed_d = '0;
					state_d       = olkid_pkg::S_DONE;
				end else if (ridx_q < cnt_q) begin
					rd_en   = 1'b1;
					rd_addr = ridx_q[IW-1:0];
					srch_d  = 1'b1;
					sidx_d  = ridx_q[IW-1:0];
					ridx_d  = ridx_q + CW'(1);
				end
			end
			olkid_pkg::S_PEEK: begin
				rd_en   = 1'b1;
				rd_addr = pos_q[IW-1:0];
				state_d = olkid_pkg::S_PEEK_WAIT;
			end
			olkid_pkg::S_PEEK_WAIT: begin
				removed_d = rd_data_s1;
				state_d   = olkid_pkg::S_PREP;
			end
			olkid_pkg::S_PREP: begin
				// Inserts move the tail up from the back, removals move it down from pos.
				if (is_ins) begin
					left_d = cnt_q - pos_q;
					ridx_d = cnt_q - CW'(1);
				end else begin
					left_d = cnt_q - pos_q - CW'(1);
					ridx_d = pos_q + CW'(1);
				end
				state_d = olkid_pkg::S_SHIFT;
			end
			olkid_pkg::S_SHIFT: begin
				if (pend_s1) begin
					wr_en   = 1'b1;
					wr_addr = dst_s1;
					wr_data = rd_data_s1;
				end
				if (left_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = ridx_q[IW-1:0];
					pend_d  = 1'b1;
					if (is_ins) begin
						dst_d  = ridx_q[IW-1:0] + IW'(1);
						ridx_d = ridx_q - CW'(1);
					end else begin
						dst_d  = ridx_q[IW-1:0] - IW'(1);
						ridx_d = ridx_q + CW'(1);
					end
					left_d = left_q - CW'(1);
				end else if (!pend_s1) begin
					if (is_ins) begin
						state_d = olkid_pkg::S_PUT;
					end else begin
						cnt_d         = cnt_q - CW'(1);
						res_status_d  = olkid_pkg::ST_OK;
						res_removed_d = removed_q;
						state_d       = olkid_pkg::S_DONE;
					end
				end
			end
			olkid_pkg::S_PUT: begin
				wr_en         = 1'b1;
				wr_addr       = pos_q[IW-1:0];
				wr_data       = value_q;
				cnt_d         = cnt_q + CW'(1);
				res_status_d  = olkid_pkg::ST_OK;
				res_removed_d = '0;
				state_d       = olkid_pkg::S_DONE;
			end
			olkid_pkg::S_DONE: begin
				if (!m_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = olkid_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = olkid_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= olkid_pkg::S_IDLE;
			cnt_q     <= '0;
			pend_s1   <= 1'b0;
			srch_s1   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pend_s1 <= pend_d;
			srch_s1 <= srch_d;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		func_q        <= func_d;
		value_q       <= value_d;
		key_q         <= key_d;
		removed_q     <= removed_d;
		pos_q         <= pos_d;
		ridx_q        <= ridx_d;
		left_q        <= left_d;
		res_status_q  <= res_status_d;
		res_removed_q <= res_removed_d;
		dst_s1        <= dst_d;
		sidx_s1       <= sidx_d;
		if (out_load) begin
			o_status_q  <= res_status_q;
			o_removed_q <= res_removed_q;
			o_count_q   <= cnt_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_W'({o_count_q, o_removed_q, o_status_q});

	`OLKID_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(CAPACITY), "entry count exceeds capacity")
	`OLKID_ASSERT_NOW(a_rw_apart, clk, arst_n, rd_en && wr_en, rd_addr != wr_addr, "read and write hit the same entry")
	`OLKID_ASSERT_NEXT(a_acc_busy, clk, arst_n, s_acc, state_q != olkid_pkg::S_IDLE, "accepted item left the sequencer idle")
	`OLKID_ASSERT_NEXT(a_idle_cnt, clk, arst_n, state_q == olkid_pkg::S_IDLE, cnt_q == $past(cnt_q), "count changed out of idle")
	`OLKID_ASSERT_NOW(a_pend_shift, clk, arst_n, pend_s1, state_q == olkid_pkg::S_SHIFT, "moved entry pending outside a shift")

endmodule

`default_nettype wire
